FILE: hw/rtl/hfti_pkg.sv
// shared types and constants for the height-field triangle interpolator
// no dependencies

package hfti_pkg;

   localparam int STORE_DEPTH = 65536;
   localparam int ADDR_W = 16;

   localparam logic [1:0] CSR_CELL_SIZE = 2'd0;
   localparam logic [1:0] CSR_VERTS_X = 2'd1;
   localparam logic [1:0] CSR_VERTS_Z = 2'd2;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // one stage of the cell-locating divider pair
   typedef struct packed {
      logic query;
      logic [ADDR_W-1:0] idx;
      logic signed [15:0] hin;
      logic oor;
      logic [24:0] rx;
      logic [24:0] rz;
      logic [7:0] qx;
      logic [7:0] qz;
      logic [16:0] d;
      logic [8:0] ex;
      logic [8:0] ez;
   } cdiv_type;

   // one stage of the rounding divider
   typedef struct packed {
      logic query;
      logic oor;
      logic [33:0] r;
      logic [15:0] q;
      logic [16:0] d;
   } qdiv_type;

endpackage

FILE: hw/rtl/hfti_if.sv
// channel interfaces for the height-field triangle interpolator
// no dependencies

interface hfti_req_if;
   logic valid;
   logic ready;
   logic func;
   logic [15:0] vertex_index;
   logic signed [15:0] height_in;
   logic signed [23:0] query_x;
   logic signed [23:0] query_z;
   modport source (output valid, func, vertex_index, height_in, query_x, query_z,
                   input ready);
   modport sink (input valid, func, vertex_index, height_in, query_x, query_z,
                 output ready);
endinterface

interface hfti_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] height_out;
   logic out_of_range;
   modport source (output valid, height_out, out_of_range, input ready);
   modport sink (input valid, height_out, out_of_range, output ready);
endinterface

interface hfti_csr_if;
   logic valid;
   logic ready;
   logic [1:0] index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/hfti_store.sv
// vertex height store: two copies, each one write port and two read ports
// depends on hfti_pkg

module hfti_store (
   input  logic clock,
   input  logic en,
   input  logic we,
   input  logic [hfti_pkg::ADDR_W-1:0] waddr,
   input  logic signed [15:0] wdata,
   input  logic [hfti_pkg::ADDR_W-1:0] base,
   input  logic [8:0] ex,
   output logic signed [15:0] h_tl,
   output logic signed [15:0] h_tr,
   output logic signed [15:0] h_bl,
   output logic signed [15:0] h_br
);
   import hfti_pkg::*;

   logic signed [15:0] mem_top [STORE_DEPTH];
   logic signed [15:0] mem_bot [STORE_DEPTH];
   logic signed [15:0] h_tl_ff, h_tr_ff, h_bl_ff, h_br_ff;
   logic [ADDR_W-1:0] a_tr, a_bl, a_br;

   assign a_tr = base + ADDR_W'(1);
   assign a_bl = base + ADDR_W'(ex);
   assign a_br = a_bl + ADDR_W'(1);

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_top[waddr] <= wdata;
         end
         h_tl_ff <= mem_top[base];
         h_tr_ff <= mem_top[a_tr];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_bot[waddr] <= wdata;
         end
         h_bl_ff <= mem_bot[a_bl];
         h_br_ff <= mem_bot[a_br];
      end
   end

   assign h_tl = h_tl_ff;
   assign h_tr = h_tr_ff;
   assign h_bl = h_bl_ff;
   assign h_br = h_br_ff;

endmodule

FILE: hw/rtl/heightfield_triangle_interp.sv
// top level of the height-field triangle interpolator
// depends on hfti_pkg, hfti_if and hfti_store

// Takes one beat per cycle while no result waits unread, writes and
// queries mixed freely. The pipeline is built around two pipelined
// restoring dividers (8 stages to locate the cell, 16 stages to round the
// blended height) and the registered read of the vertex store,
// which is kept in two copies so the four corners of a cell read together.
// Writes reach the store in the same stage as query reads, so items act in
// the order taken. The whole pipeline holds while a result waits unread.
module heightfield_triangle_interp (
   input  logic clock,
   input  logic reset,
   hfti_req_if.sink req_bus,
   hfti_rsp_if.source rsp_bus,
   hfti_csr_if.sink csr_bus
);
   import hfti_pkg::*;

   logic [15:0] cell_size_ff;
   logic [8:0] verts_x_ff, verts_z_ff;
   logic adv;

   // stage a
   logic a_vld_ff;
   logic a_func_ff;
   logic [ADDR_W-1:0] a_idx_ff;
   logic signed [15:0] a_hin_ff;
   logic signed [23:0] a_qx_ff, a_qz_ff;
   // stage b
   logic b_vld_ff, b_query_ff;
   logic [ADDR_W-1:0] b_idx_ff;
   logic signed [15:0] b_hin_ff;
   logic signed [24:0] b_x2_ff, b_z2_ff;
   logic [23:0] b_w_ff, b_l_ff;
   logic [16:0] b_d_ff;
   logic [8:0] b_ex_ff, b_ez_ff;
   // stage c and divider
   logic c_vld_ff;
   cdiv_type c_ff, c_in;
   logic [7:0] dv_vld_ff;
   cdiv_type dv_ff [8];
   cdiv_type dv_in [8];
   // stage m
   logic m_vld_ff, m_query_ff, m_oor_ff, m_up_ff;
   logic [ADDR_W-1:0] m_idx_ff, m_base_ff;
   logic signed [15:0] m_hin_ff;
   logic [8:0] m_ex_ff;
   logic [16:0] m_d_ff, m_wa_ff, m_wb_ff, m_wc_ff;
   // stage r
   logic r_vld_ff, r_oor_ff, r_up_ff;
   logic [16:0] r_d_ff, r_wa_ff, r_wb_ff, r_wc_ff;
   // stage p
   logic p_vld_ff, p_oor_ff;
   logic signed [33:0] p_pa_ff, p_pb_ff, p_pc_ff;
   logic [16:0] p_d_ff;
   // stage s and rounding divider
   logic s_vld_ff;
   qdiv_type s_ff, s_in;
   logic [15:0] qv_vld_ff;
   qdiv_type qv_ff [16];
   qdiv_type qv_in [16];
   // output
   logic rsp_valid_ff, rsp_oor_ff;
   logic signed [15:0] rsp_height_ff;

   logic signed [15:0] h_tl, h_tr, h_bl, h_br;

   assign adv = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign csr_bus.ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= 16'd256;
         verts_x_ff <= 9'd256;
         verts_z_ff <= 9'd256;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_CELL_SIZE: cell_size_ff <= csr_bus.data;
            CSR_VERTS_X: verts_x_ff <= csr_bus.data[8:0];
            CSR_VERTS_Z: verts_z_ff <= csr_bus.data[8:0];
            default: ;
         endcase
      end
   end

   // saturated counts and effective spacing
   logic [8:0] ex_sat, ez_sat;
   logic [15:0] cs_eff;
   logic [7:0] exm1, ezm1;

   always_comb begin
      ex_sat = (verts_x_ff < 9'd2) ? 9'd2 : (verts_x_ff > 9'd256) ? 9'd256 : verts_x_ff;
      ez_sat = (verts_z_ff < 9'd2) ? 9'd2 : (verts_z_ff > 9'd256) ? 9'd256 : verts_z_ff;
      cs_eff = (cell_size_ff == 16'd0) ? 16'd1 : cell_size_ff;
      exm1 = 8'(ex_sat - 9'd1);
      ezm1 = 8'(ez_sat - 9'd1);
   end

   // front stages: register beat, grid extents, range check
   logic signed [25:0] x2s, z2s, ws, ls;

   always_comb begin
      x2s = 26'(b_x2_ff);
      z2s = 26'(b_z2_ff);
      ws = signed'({2'b00, b_w_ff});
      ls = signed'({2'b00, b_l_ff});
      c_in.query = b_query_ff;
      c_in.idx = b_idx_ff;
      c_in.hin = b_hin_ff;
      c_in.oor = (x2s < -ws) || (x2s > ws) || (z2s < -ls) || (z2s > ls);
      c_in.rx = 25'(x2s + ws);
      c_in.rz = 25'(z2s + ls);
      c_in.qx = 8'd0;
      c_in.qz = 8'd0;
      c_in.d = b_d_ff;
      c_in.ex = b_ex_ff;
      c_in.ez = b_ez_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_bus.valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_func_ff <= req_bus.func;
         a_idx_ff <= req_bus.vertex_index;
         a_hin_ff <= req_bus.height_in;
         a_qx_ff <= req_bus.query_x;
         a_qz_ff <= req_bus.query_z;
         b_query_ff <= (a_func_ff == FUNC_QUERY);
         b_idx_ff <= a_idx_ff;
         b_hin_ff <= a_hin_ff;
         b_x2_ff <= {a_qx_ff, 1'b0};
         b_z2_ff <= {a_qz_ff, 1'b0};
         b_w_ff <= cs_eff * exm1;
         b_l_ff <= cs_eff * ezm1;
         b_d_ff <= {cs_eff, 1'b0};
         b_ex_ff <= ex_sat;
         b_ez_ff <= ez_sat;
         c_ff <= c_in;
      end
   end

   // cell divider: one quotient bit of column and row per stage
   always_comb begin
      cdiv_type src;
      logic [24:0] dk;
      for (int j = 0; j < 8; j++) begin
         src = (j == 0) ? c_ff : dv_ff[j-1];
         dk = {8'd0, src.d} << (7 - j);
         dv_in[j] = src;
         if (src.rx >= dk) begin
            dv_in[j].rx = src.rx - dk;
            dv_in[j].qx[7-j] = 1'b1;
         end
         if (src.rz >= dk) begin
            dv_in[j].rz = src.rz - dk;
            dv_in[j].qz[7-j] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff <= '0;
      end else if (adv) begin
         dv_vld_ff <= {dv_vld_ff[6:0], c_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 8; j++) begin
            dv_ff[j] <= dv_in[j];
         end
      end
   end

   // far-edge clamp, base address and triangle weights
   cdiv_type e;
   logic [8:0] ex2, ez2;
   logic [7:0] col, row;
   logic [16:0] rx, rz;
   logic [17:0] rsum, d18;
   logic up;
   logic [16:0] wa, wb, wc;
   logic [16:0] base_full;

   always_comb begin
      e = dv_ff[7];
      ex2 = e.ex - 9'd2;
      ez2 = e.ez - 9'd2;
      col = e.qx;
      row = e.qz;
      rx = e.rx[16:0];
      rz = e.rz[16:0];
      if ({1'b0, e.qx} > ex2) begin
         col = ex2[7:0];
         rx = e.rx[16:0] + e.d;
      end
      if ({1'b0, e.qz} > ez2) begin
         row = ez2[7:0];
         rz = e.rz[16:0] + e.d;
      end
      rsum = {1'b0, rx} + {1'b0, rz};
      d18 = {1'b0, e.d};
      up = rsum > d18;
      if (up) begin
         wa = e.d - rz;
         wb = e.d - rx;
         wc = 17'(rsum - d18);
      end else begin
         wa = rx;
         wb = rz;
         wc = 17'(d18 - rsum);
      end
      base_full = row * e.ex + {9'd0, col};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
         r_vld_ff <= 1'b0;
         p_vld_ff <= 1'b0;
         s_vld_ff <= 1'b0;
      end else if (adv) begin
         m_vld_ff <= dv_vld_ff[7];
         r_vld_ff <= m_vld_ff && m_query_ff;
         p_vld_ff <= r_vld_ff;
         s_vld_ff <= p_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_query_ff <= e.query;
         m_oor_ff <= e.oor;
         m_idx_ff <= e.idx;
         m_hin_ff <= e.hin;
         m_base_ff <= base_full[ADDR_W-1:0];
         m_ex_ff <= e.ex;
         m_d_ff <= e.d;
         m_up_ff <= up;
         m_wa_ff <= wa;
         m_wb_ff <= wb;
         m_wc_ff <= wc;
      end
   end

   hfti_store u_store (
      .clock(clock),
      .en(adv),
      .we(m_vld_ff && !m_query_ff),
      .waddr(m_idx_ff),
      .wdata(m_hin_ff),
      .base(m_base_ff),
      .ex(m_ex_ff),
      .h_tl(h_tl),
      .h_tr(h_tr),
      .h_bl(h_bl),
      .h_br(h_br)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         r_oor_ff <= m_oor_ff;
         r_up_ff <= m_up_ff;
         r_d_ff <= m_d_ff;
         r_wa_ff <= m_wa_ff;
         r_wb_ff <= m_wb_ff;
         r_wc_ff <= m_wc_ff;
         p_oor_ff <= r_oor_ff;
         p_d_ff <= r_d_ff;
         p_pa_ff <= signed'({1'b0, r_wa_ff}) * h_tr;
         p_pb_ff <= signed'({1'b0, r_wb_ff}) * h_bl;
         p_pc_ff <= signed'({1'b0, r_wc_ff}) * (r_up_ff ? h_br : h_tl);
         s_ff <= s_in;
      end
   end

   // biased sum so the rounding divide works on a positive value
   logic signed [35:0] t_sum;

   always_comb begin
      t_sum = 36'(p_pa_ff) + 36'(p_pb_ff) + 36'(p_pc_ff)
            + signed'({4'd0, p_d_ff, 15'd0}) + signed'({20'd0, p_d_ff[16:1]});
      s_in.query = 1'b1;
      s_in.oor = p_oor_ff;
      s_in.r = t_sum[33:0];
      s_in.q = 16'd0;
      s_in.d = p_d_ff;
   end

   // rounding divider: one quotient bit per stage
   always_comb begin
      qdiv_type src;
      logic [33:0] dk;
      for (int j = 0; j < 16; j++) begin
         src = (j == 0) ? s_ff : qv_ff[j-1];
         dk = {17'd0, src.d} << (15 - j);
         qv_in[j] = src;
         if (src.r >= dk) begin
            qv_in[j].r = src.r - dk;
            qv_in[j].q[15-j] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qv_vld_ff <= '0;
      end else if (adv) begin
         qv_vld_ff <= {qv_vld_ff[14:0], s_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 16; j++) begin
            qv_ff[j] <= qv_in[j];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= qv_vld_ff[15] && qv_ff[15].query;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_oor_ff <= qv_ff[15].oor;
         rsp_height_ff <= qv_ff[15].oor ? 16'sd0
                        : signed'({~qv_ff[15].q[15], qv_ff[15].q[14:0]});
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.out_of_range = rsp_oor_ff;
   assign rsp_bus.height_out = rsp_height_ff;

`ifndef ASSERT_OFF
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_oor_ff |-> rsp_height_ff == 16'sd0)
      else $error("out-of-range beat with nonzero height");

   a_addr_in_store: assert property (@(posedge clock) disable iff (reset)
      m_vld_ff && m_query_ff && !m_oor_ff
      |-> ({1'b0, m_base_ff} + {8'd0, m_ex_ff}) < 17'h10000)
      else $error("corner address past end of store");

   a_weights_sum: assert property (@(posedge clock) disable iff (reset)
      m_vld_ff && m_query_ff && !m_oor_ff
      |-> ({1'b0, m_wa_ff} + {1'b0, m_wb_ff} + {1'b0, m_wc_ff}) == {1'b0, m_d_ff})
      else $error("triangle weights do not sum to cell width");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |=> rsp_valid_ff && $stable(rsp_height_ff))
      else $error("result lost under stall");
`endif

endmodule
